// ===== design/ctfi_pkg.sv =====
// Shared types and constants for the charge trajectory field integrator.
package ctfi_pkg;

    typedef enum logic [36:0] {
        S_IDLE = 37'b1 << 0,
        S_RST  = 37'b1 << 1,
        F_SRC  = 37'b1 << 2,
        F_NORM = 37'b1 << 3,
        F_MXX  = 37'b1 << 4,
        F_MYY  = 37'b1 << 5,
        F_SQ0  = 37'b1 << 6,
        F_SQRT = 37'b1 << 7,
        F_DIV0 = 37'b1 << 8,
        F_DIV  = 37'b1 << 9,
        F_F2   = 37'b1 << 10,
        F_F3   = 37'b1 << 11,
        F_F4   = 37'b1 << 12,
        F_TX   = 37'b1 << 13,
        F_AX   = 37'b1 << 14,
        F_TY   = 37'b1 << 15,
        F_AY   = 37'b1 << 16,
        F_AYA  = 37'b1 << 17,
        F_Q1   = 37'b1 << 18,
        F_Q2   = 37'b1 << 19,
        F_Q3   = 37'b1 << 20,
        F_Q4   = 37'b1 << 21,
        F_Q5   = 37'b1 << 22,
        F_Q6   = 37'b1 << 23,
        S_HSUM = 37'b1 << 24,
        S_HM1  = 37'b1 << 25,
        S_HM2  = 37'b1 << 26,
        S_HM3  = 37'b1 << 27,
        S_HADD = 37'b1 << 28,
        S_UPD  = 37'b1 << 29,
        S_PX   = 37'b1 << 30,
        S_PX2  = 37'b1 << 31,
        S_PX3  = 37'b1 << 32,
        S_PY   = 37'b1 << 33,
        S_PY2  = 37'b1 << 34,
        S_PY3  = 37'b1 << 35,
        S_EMIT = 37'b1 << 36
    } state_t;

    typedef enum logic [1:0] {
        OP_WRITE   = 2'd0,
        OP_RESTART = 2'd1,
        OP_STEP    = 2'd2,
        OP_NONE    = 2'd3
    } opcode_t;

    localparam logic [2:0] CFG_WIDTH  = 3'd0;
    localparam logic [2:0] CFG_HEIGHT = 3'd1;
    localparam logic [2:0] CFG_CHARGE = 3'd2;
    localparam logic [2:0] CFG_STEP   = 3'd3;
    localparam logic [2:0] CFG_SCALE  = 3'd4;

    localparam logic [12:0] RST_WIDTH  = 13'd640;
    localparam logic [12:0] RST_HEIGHT = 13'd480;
    localparam logic [31:0] RST_CHARGE_Q = 32'd10000000;
    localparam logic [15:0] RST_DT     = 16'd6554;
    localparam logic [4:0]  RST_SCALE  = 5'd2;

    localparam logic [15:0] RST_SRC_C [4] = '{16'h0100, 16'hFF00, 16'hFF00, 16'h0100};
    localparam logic [31:0] RST_SRC_X [4] = '{32'hFFFF0000, 32'h00010000,
                                              32'hFFFF0000, 32'h00010000};
    localparam logic [31:0] RST_SRC_Y [4] = '{32'h00010000, 32'h00010000,
                                              32'hFFFF0000, 32'hFFFF0000};

    localparam logic [63:0] SAT_MAX    = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SAT_MIN    = 64'h8000_0000_0000_0000;
    localparam logic [63:0] SQRT_START = 64'h4000_0000_0000_0000;
    localparam logic [63:0] RECIP_NUM  = 64'h2000_0000_0000_0000;
    localparam logic [25:0] RECIP_TEN  = 26'd6554;
    localparam logic [5:0]  DIV_LAST   = 6'd63;

endpackage

// ===== design/charge_trajectory_field_integrator.sv =====
// Charge trajectory field integrator: sequencer and shared datapath.
// A source write or an ignored opcode is handled in the idle state; a restart sets the start point
// and then runs one field evaluation; a step while moving runs one field evaluation plus two divides.
// A field evaluation runs, per source, a bit-serial normalize, a square root and a divide on the
// shared divider; a step while stopped goes straight to the result.
// One request at a time; the result register lets the next request in while a result waits.
// Reset: default registers, default source table, motion state zero, stepping stopped.
module charge_trajectory_field_integrator
    import ctfi_pkg::*;
#(
    parameter int NUM_SOURCES = 4,
    parameter int MAX_DIM     = 4096
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         opcode,
    input  logic [1:0]         source_index,
    input  logic signed [15:0] source_charge,
    input  logic signed [31:0] source_x,
    input  logic signed [31:0] source_y,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [12:0]        pixel_x,
    output logic [12:0]        pixel_y,
    output logic               left_frame,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    localparam int SI_W  = $clog2(NUM_SOURCES + 1);
    localparam int IDX_W = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
    localparam logic [SI_W-1:0] SI_END = SI_W'(NUM_SOURCES);
    localparam logic [13:0] DIM_CAP = 14'(MAX_DIM);

    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] s;
        s = a + b;
        if (!a[63] && !b[63] && s[63]) return SAT_MAX;
        if (a[63] && b[63] && !s[63]) return SAT_MIN;
        return s;
    endfunction

    function automatic logic [63:0] sat_sub(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] s;
        s = a - b;
        if (!a[63] && b[63] && s[63]) return SAT_MAX;
        if (a[63] && !b[63] && !s[63]) return SAT_MIN;
        return s;
    endfunction

    function automatic logic [63:0] mag(input logic [63:0] v);
        return v[63] ? (64'd0 - v) : v;
    endfunction

    function automatic logic [63:0] from_sm(input logic neg, input logic [63:0] m);
        if (neg) return m[63] ? SAT_MIN : (64'd0 - m);
        return m[63] ? SAT_MAX : m;
    endfunction

    // Scale by 2^(-2-2e): truncate on the right, saturate on the left.
    function automatic logic [63:0] scale_term(input logic [63:0] t, input logic [7:0] e);
        logic signed [8:0] k;
        logic [8:0]        nk;
        logic [127:0]      w;
        k  = -9'sd2 - ($signed({e[7], e}) <<< 1);
        nk = 9'd0 - k;
        w  = {64'd0, t} << k[5:0];
        if (!k[8]) return (w[127:64] != 64'd0) ? '1 : w[63:0];
        if (nk >= 9'd64) return 64'd0;
        return t >> nk[5:0];
    endfunction

    function automatic logic [12:0] to_pixel(input logic [63:0] v, input logic [12:0] lim);
        if (v[63]) return 13'd0;
        return (v[62:32] > 31'(lim)) ? lim : v[44:32];
    endfunction

    function automatic logic inside_frame(input logic [12:0] x, input logic [12:0] y,
                                          input logic [12:0] w, input logic [12:0] h);
        return (x != 13'd0) && (x < w) && (y != 13'd0) && (y < h);
    endfunction

    state_t state_reg;
    state_t div_ret_reg;

    logic [12:0] frame_width_reg, frame_height_reg;
    logic [31:0] test_charge_reg;
    logic [15:0] time_step_reg;
    logic [4:0]  pixel_scale_reg;

    logic [15:0] src_c_reg [NUM_SOURCES];
    logic [31:0] src_x_reg [NUM_SOURCES];
    logic [31:0] src_y_reg [NUM_SOURCES];

    logic [63:0] pos_x_reg, pos_y_reg, vel_x_reg, vel_y_reg;
    logic [63:0] pvel_x_reg, pvel_y_reg, pacc_x_reg, pacc_y_reg;
    logic [12:0] cur_px_reg, cur_py_reg;
    logic        stopped_reg;

    logic [SI_W-1:0] si_reg;
    logic [1:0]      ph_reg;
    logic [5:0]      cnt_reg;
    logic            rst_mode_reg;

    logic        out_valid_reg, left_frame_reg;
    logic [12:0] pixel_x_reg, pixel_y_reg;

    logic [63:0] xs_reg, ys_reg;
    logic [7:0]  e_reg;
    logic        neg_x_reg, neg_y_reg;
    logic [63:0] sq_v_reg, sq_r_reg, sq_bit_reg;
    logic [63:0] div_q_reg;
    logic [31:0] div_rem_reg, div_dv_reg;
    logic [63:0] mul_p_reg;
    logic [31:0] f3_reg;
    logic [63:0] term_reg, hold_reg, ex_reg, ey_reg, ax_reg, ay_reg;

    logic accept, emit_load;
    logic [IDX_W-1:0] cur_idx;
    logic [15:0] c_cur, cm;
    logic [63:0] sx_ext, sy_ext, dx, dy, mx, my, m0, nm;
    logic [12:0] w_eff, h_eff;
    logic [4:0]  s_eff;
    logic [31:0] qm;
    logic [63:0] exm, eym, tm;
    logic [63:0] sq_rb;
    logic [32:0] div_sh, div_sub;
    logic        div_ge;
    logic [32:0] prod_mid;
    logic [63:0] prod_q, fx_new, fy_new, half_m, term_sc;
    logic [63:0] hsum_a, hsum_b, hadd_t, hadd_sum;
    logic [12:0] px_new, py_new;
    logic [31:0] mul_a, mul_b;
    logic [25:0] wx;
    logic signed [13:0] rd;
    logic signed [5:0]  rs;
    logic signed [19:0] rp;
    logic [63:0] rst_pos, wh64, hh64;

    assign in_stall   = (state_reg != S_IDLE);
    assign accept     = in_valid && !in_stall;
    assign cfg_ready  = 1'b1;
    assign out_valid  = out_valid_reg;
    assign pixel_x    = pixel_x_reg;
    assign pixel_y    = pixel_y_reg;
    assign left_frame = left_frame_reg;
    assign emit_load  = (state_reg == S_EMIT) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        w_eff = ({1'b0, frame_width_reg} > DIM_CAP) ? DIM_CAP[12:0] : frame_width_reg;
        h_eff = ({1'b0, frame_height_reg} > DIM_CAP) ? DIM_CAP[12:0] : frame_height_reg;
        s_eff = (pixel_scale_reg == 5'd0) ? 5'd1 : pixel_scale_reg;
        qm    = test_charge_reg[31] ? (32'd0 - test_charge_reg) : test_charge_reg;

        cur_idx = si_reg[IDX_W-1:0];
        c_cur   = src_c_reg[cur_idx];
        cm      = c_cur[15] ? (16'd0 - c_cur) : c_cur;
        sx_ext  = {{16{src_x_reg[cur_idx][31]}}, src_x_reg[cur_idx], 16'd0};
        sy_ext  = {{16{src_y_reg[cur_idx][31]}}, src_y_reg[cur_idx], 16'd0};
        dx      = sat_sub(pos_x_reg, sx_ext);
        dy      = sat_sub(pos_y_reg, sy_ext);
        mx      = mag(dx);
        my      = mag(dy);
        m0      = (mx > my) ? mx : my;
        nm      = (xs_reg > ys_reg) ? xs_reg : ys_reg;

        sq_rb   = sq_r_reg + sq_bit_reg;
        div_sh  = {div_rem_reg, div_q_reg[63]};
        div_sub = div_sh - {1'b0, div_dv_reg};
        div_ge  = (div_sh >= {1'b0, div_dv_reg});

        exm = mag(ex_reg);
        eym = mag(ey_reg);
        tm  = mag(term_reg);

        // 64x32 product from two 32x32 halves, saturated to the unsigned range
        prod_mid = {1'b0, hold_reg[31:0]} + {1'b0, mul_p_reg[63:32]};
        prod_q   = ((hold_reg[63:32] != 32'd0) || prod_mid[32]) ? '1
                                                                 : {prod_mid[31:0], mul_p_reg[31:0]};
        fx_new   = from_sm(test_charge_reg[31] ^ ex_reg[63], prod_q);
        fy_new   = from_sm(test_charge_reg[31] ^ ey_reg[63], prod_q);
        half_m   = (hold_reg << 15) + (mul_p_reg >> 17);
        term_sc  = scale_term(mul_p_reg, e_reg);

        unique case (ph_reg)
            2'd0:
            begin
                hsum_a = ax_reg;    hsum_b = pacc_x_reg; hadd_t = vel_x_reg;
            end
            2'd1:
            begin
                hsum_a = ay_reg;    hsum_b = pacc_y_reg; hadd_t = vel_y_reg;
            end
            2'd2:
            begin
                hsum_a = vel_x_reg; hsum_b = pvel_x_reg; hadd_t = pos_x_reg;
            end
            default:
            begin
                hsum_a = vel_y_reg; hsum_b = pvel_y_reg; hadd_t = pos_y_reg;
            end
        endcase
        hadd_sum = sat_add(hadd_t, term_reg);

        px_new = to_pixel(term_reg, w_eff);
        py_new = to_pixel(term_reg, h_eff);
        wh64   = {20'd0, w_eff[12:1], 32'd0};
        hh64   = {20'd0, h_eff[12:1], 32'd0};

        wx      = 26'(w_eff) * RECIP_TEN;
        rd      = $signed({1'b0, cur_px_reg}) - $signed({2'b0, w_eff[12:1]});
        rs      = $signed({1'b0, s_eff});
        rp      = rd * rs;
        rst_pos = {{12{rp[19]}}, rp, 32'd0};

        mul_a = 32'd0;
        mul_b = 32'd0;
        unique case (state_reg)
            F_MXX:
            begin
                mul_a = xs_reg[31:0];       mul_b = xs_reg[31:0];
            end
            F_MYY:
            begin
                mul_a = ys_reg[31:0];       mul_b = ys_reg[31:0];
            end
            F_F2:
            begin
                mul_a = div_q_reg[31:0];    mul_b = div_q_reg[31:0];
            end
            F_F3:
            begin
                mul_a = mul_p_reg[62:31];   mul_b = div_q_reg[31:0];
            end
            F_F4:
            begin
                mul_a = xs_reg[31:0];       mul_b = mul_p_reg[62:31];
            end
            F_TX, F_TY:
            begin
                mul_a = {16'd0, cm};        mul_b = mul_p_reg[62:31];
            end
            F_AX:
            begin
                mul_a = ys_reg[31:0];       mul_b = f3_reg;
            end
            F_Q1:
            begin
                mul_a = exm[63:32];         mul_b = qm;
            end
            F_Q2:
            begin
                mul_a = exm[31:0];          mul_b = qm;
            end
            F_Q4:
            begin
                mul_a = eym[63:32];         mul_b = qm;
            end
            F_Q5:
            begin
                mul_a = eym[31:0];          mul_b = qm;
            end
            S_HM1:
            begin
                mul_a = tm[63:32];          mul_b = {16'd0, time_step_reg};
            end
            S_HM2:
            begin
                mul_a = tm[31:0];           mul_b = {16'd0, time_step_reg};
            end
            default:
            begin
                mul_a = 32'd0;              mul_b = 32'd0;
            end
        endcase
    end

    // Source table and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SOURCES; i++)
            begin
                src_c_reg[i] <= (i < 4) ? RST_SRC_C[2'(i)] : 16'd0;
                src_x_reg[i] <= (i < 4) ? RST_SRC_X[2'(i)] : 32'd0;
                src_y_reg[i] <= (i < 4) ? RST_SRC_Y[2'(i)] : 32'd0;
            end
            frame_width_reg  <= RST_WIDTH;
            frame_height_reg <= RST_HEIGHT;
            test_charge_reg  <= RST_CHARGE_Q;
            time_step_reg    <= RST_DT;
            pixel_scale_reg  <= RST_SCALE;
        end
        else
        begin
            if (accept && (opcode == OP_WRITE))
            begin
                for (int i = 0; i < NUM_SOURCES; i++)
                begin
                    if (32'(source_index) == i)
                    begin
                        src_c_reg[i] <= source_charge;
                        src_x_reg[i] <= source_x;
                        src_y_reg[i] <= source_y;
                    end
                end
            end
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_WIDTH:  frame_width_reg  <= cfg_data[12:0];
                    CFG_HEIGHT: frame_height_reg <= cfg_data[12:0];
                    CFG_CHARGE: test_charge_reg  <= cfg_data;
                    CFG_STEP:   time_step_reg    <= cfg_data[15:0];
                    CFG_SCALE:  pixel_scale_reg  <= cfg_data[4:0];
                    default:    ;
                endcase
            end
        end
    end

    // Sequencer and motion state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            div_ret_reg    <= S_IDLE;
            pos_x_reg      <= '0;
            pos_y_reg      <= '0;
            vel_x_reg      <= '0;
            vel_y_reg      <= '0;
            pvel_x_reg     <= '0;
            pvel_y_reg     <= '0;
            pacc_x_reg     <= '0;
            pacc_y_reg     <= '0;
            cur_px_reg     <= '0;
            cur_py_reg     <= '0;
            stopped_reg    <= 1'b1;
            si_reg         <= '0;
            ph_reg         <= '0;
            cnt_reg        <= '0;
            rst_mode_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (emit_load)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        unique case (opcode)
                            OP_RESTART:
                            begin
                                cur_px_reg <= 13'(wx[25:16]);
                                cur_py_reg <= {1'b0, h_eff[12:1]};
                                vel_x_reg  <= '0;
                                vel_y_reg  <= '0;
                                pvel_x_reg <= '0;
                                pvel_y_reg <= '0;
                                state_reg  <= S_RST;
                            end
                            OP_STEP:
                            begin
                                if (stopped_reg)
                                    state_reg <= S_EMIT;
                                else
                                begin
                                    si_reg       <= '0;
                                    rst_mode_reg <= 1'b0;
                                    state_reg    <= F_SRC;
                                end
                            end
                            OP_WRITE, OP_NONE: ;
                        endcase
                    end
                end
                S_RST:
                begin
                    pos_x_reg    <= rst_pos;
                    pos_y_reg    <= '0;
                    stopped_reg  <= !inside_frame(cur_px_reg, cur_py_reg, w_eff, h_eff);
                    si_reg       <= '0;
                    rst_mode_reg <= 1'b1;
                    state_reg    <= F_SRC;
                end
                F_SRC:
                begin
                    if (si_reg == SI_END)
                        state_reg <= F_Q1;
                    else if (m0 == 64'd0)
                        si_reg <= si_reg + 1'b1;
                    else
                        state_reg <= F_NORM;
                end
                F_NORM:
                begin
                    if ((nm[63:31] == 33'd0) && nm[30])
                        state_reg <= F_MXX;
                end
                F_MXX:  state_reg <= F_MYY;
                F_MYY:  state_reg <= F_SQ0;
                F_SQ0:  state_reg <= F_SQRT;
                F_SQRT:
                begin
                    if (sq_bit_reg[0])
                        state_reg <= F_DIV0;
                end
                F_DIV0:
                begin
                    cnt_reg     <= '0;
                    div_ret_reg <= F_F2;
                    state_reg   <= F_DIV;
                end
                F_DIV:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == DIV_LAST)
                        state_reg <= div_ret_reg;
                end
                F_F2:   state_reg <= F_F3;
                F_F3:   state_reg <= F_F4;
                F_F4:   state_reg <= F_TX;
                F_TX:   state_reg <= F_AX;
                F_AX:   state_reg <= F_TY;
                F_TY:   state_reg <= F_AY;
                F_AY:   state_reg <= F_AYA;
                F_AYA:
                begin
                    si_reg    <= si_reg + 1'b1;
                    state_reg <= F_SRC;
                end
                F_Q1:   state_reg <= F_Q2;
                F_Q2:   state_reg <= F_Q3;
                F_Q3:   state_reg <= F_Q4;
                F_Q4:   state_reg <= F_Q5;
                F_Q5:   state_reg <= F_Q6;
                F_Q6:
                begin
                    if (rst_mode_reg)
                    begin
                        pacc_x_reg <= ax_reg;
                        pacc_y_reg <= fy_new;
                        state_reg  <= S_IDLE;
                    end
                    else
                    begin
                        ph_reg    <= '0;
                        state_reg <= S_HSUM;
                    end
                end
                S_HSUM: state_reg <= S_HM1;
                S_HM1:  state_reg <= S_HM2;
                S_HM2:  state_reg <= S_HM3;
                S_HM3:  state_reg <= S_HADD;
                S_HADD:
                begin
                    unique case (ph_reg)
                        2'd0:    vel_x_reg <= hadd_sum;
                        2'd1:    vel_y_reg <= hadd_sum;
                        2'd2:    pos_x_reg <= hadd_sum;
                        default: pos_y_reg <= hadd_sum;
                    endcase
                    ph_reg    <= ph_reg + 1'b1;
                    state_reg <= (ph_reg == 2'd3) ? S_UPD : S_HSUM;
                end
                S_UPD:
                begin
                    pvel_x_reg  <= vel_x_reg;
                    pvel_y_reg  <= vel_y_reg;
                    pacc_x_reg  <= ax_reg;
                    pacc_y_reg  <= ay_reg;
                    cnt_reg     <= '0;
                    div_ret_reg <= S_PX;
                    state_reg   <= F_DIV;
                end
                S_PX:   state_reg <= S_PX2;
                S_PX2:  state_reg <= S_PX3;
                S_PX3:
                begin
                    cur_px_reg  <= px_new;
                    cnt_reg     <= '0;
                    div_ret_reg <= S_PY;
                    state_reg   <= F_DIV;
                end
                S_PY:   state_reg <= S_PY2;
                S_PY2:  state_reg <= S_PY3;
                S_PY3:
                begin
                    cur_py_reg  <= py_new;
                    stopped_reg <= !inside_frame(cur_px_reg, py_new, w_eff, h_eff);
                    state_reg   <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (emit_load)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (emit_load)
        begin
            pixel_x_reg    <= cur_px_reg;
            pixel_y_reg    <= cur_py_reg;
            left_frame_reg <= stopped_reg;
        end
    end

    // Shared datapath: multiplier, normalizer, square root, divider, accumulators
    always_ff @(posedge clk)
    begin
        mul_p_reg <= mul_a * mul_b;

        unique case (state_reg)
            S_IDLE, S_RST:
            begin
                ex_reg <= '0;
                ey_reg <= '0;
            end
            F_SRC:
            begin
                xs_reg    <= mx;
                ys_reg    <= my;
                e_reg     <= '0;
                neg_x_reg <= dx[63] ^ c_cur[15];
                neg_y_reg <= dy[63] ^ c_cur[15];
            end
            F_NORM:
            begin
                if (nm[63:31] != 33'd0)
                begin
                    xs_reg <= xs_reg >> 1;
                    ys_reg <= ys_reg >> 1;
                    e_reg  <= e_reg + 8'd1;
                end
                else if (!nm[30])
                begin
                    xs_reg <= xs_reg << 1;
                    ys_reg <= ys_reg << 1;
                    e_reg  <= e_reg - 8'd1;
                end
            end
            F_MYY:  sq_v_reg <= mul_p_reg;
            F_SQ0:
            begin
                sq_v_reg   <= sq_v_reg + mul_p_reg;
                sq_r_reg   <= '0;
                sq_bit_reg <= SQRT_START;
            end
            F_SQRT:
            begin
                if (sq_v_reg >= sq_rb)
                begin
                    sq_v_reg <= sq_v_reg - sq_rb;
                    sq_r_reg <= (sq_r_reg >> 1) + sq_bit_reg;
                end
                else
                    sq_r_reg <= sq_r_reg >> 1;
                sq_bit_reg <= sq_bit_reg >> 2;
            end
            F_DIV0:
            begin
                div_q_reg   <= RECIP_NUM;
                div_rem_reg <= '0;
                div_dv_reg  <= sq_r_reg[31:0];
            end
            S_UPD:
            begin
                div_q_reg   <= mag(pos_x_reg);
                div_rem_reg <= '0;
                div_dv_reg  <= 32'(s_eff);
            end
            S_PX3:
            begin
                div_q_reg   <= mag(pos_y_reg);
                div_rem_reg <= '0;
                div_dv_reg  <= 32'(s_eff);
            end
            F_DIV:
            begin
                div_rem_reg <= div_ge ? div_sub[31:0] : div_sh[31:0];
                div_q_reg   <= {div_q_reg[62:0], div_ge};
            end
            F_F4:   f3_reg   <= mul_p_reg[62:31];
            F_AX:   term_reg <= from_sm(neg_x_reg, term_sc);
            F_TY:   ex_reg   <= sat_add(ex_reg, term_reg);
            F_AY:   term_reg <= from_sm(neg_y_reg, term_sc);
            F_AYA:  ey_reg   <= sat_add(ey_reg, term_reg);
            F_Q2, F_Q5, S_HM2:
                hold_reg <= mul_p_reg;
            F_Q3:   ax_reg   <= fx_new;
            F_Q6:   ay_reg   <= fy_new;
            S_HSUM: term_reg <= sat_add(hsum_a, hsum_b);
            S_HM3:  term_reg <= from_sm(term_reg[63], half_m);
            S_PX:   term_reg <= from_sm(pos_x_reg[63], div_q_reg);
            S_PX2:  term_reg <= sat_add(term_reg, wh64);
            S_PY:   term_reg <= from_sm(pos_y_reg[63], div_q_reg);
            S_PY2:  term_reg <= sat_sub(hh64, term_reg);
            default: ;
        endcase
    end

    // The normalizer must leave both components below 2^31 with the larger at least 2^30.
    a_norm_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == F_MXX) |-> ((xs_reg[63:31] == 33'd0) && (ys_reg[63:31] == 33'd0)
                                  && (xs_reg[30] || ys_reg[30])))
        else $error("normalized distance out of range");

    // The root fed to the reciprocal divide is a nonzero 32-bit value.
    a_root_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == F_DIV0) |-> ((sq_r_reg[63:32] == 32'd0) && (sq_r_reg[31:30] != 2'b00)))
        else $error("square root out of range before divide");

    // A new result carries the current stop flag.
    a_emit_flag: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> (left_frame_reg == stopped_reg))
        else $error("left_frame does not match stop state");

    // A step while stopped goes straight to the result.
    a_stopped_step: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (opcode == OP_STEP) && stopped_reg) |=> (state_reg == S_EMIT))
        else $error("stopped step did not emit at once");

endmodule

// ===== sim/charge_trajectory_field_integrator_test.sv =====
// Self-checking testbench for the charge trajectory field integrator.
module charge_trajectory_field_integrator_test;
    import ctfi_pkg::*;

    localparam int WATCHDOG_LIMIT = 60000;
    localparam int SETTLE_CYCLES  = 1200;
    localparam int HOLD_CYCLES    = 3000;

    typedef struct {
        opcode_t            op;
        logic [1:0]         idx;
        logic signed [15:0] charge;
        logic signed [31:0] x;
        logic signed [31:0] y;
    } request_t;

    typedef struct {
        logic [12:0] px;
        logic [12:0] py;
        logic        left;
    } pixel_t;

    typedef struct {
        logic signed [63:0] fx;
        logic signed [63:0] fy;
    } force_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [1:0]         opcode = OP_NONE;
    logic [1:0]         source_index = '0;
    logic signed [15:0] source_charge = '0;
    logic signed [31:0] source_x = '0;
    logic signed [31:0] source_y = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [12:0]        pixel_x;
    logic [12:0]        pixel_y;
    logic               left_frame;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [2:0]         cfg_index = '0;
    logic [31:0]        cfg_data = '0;

    charge_trajectory_field_integrator DUT (.*);

    initial begin
        forever #2 clk = ~clk;
    end

    // predictor state
    logic signed [15:0] tbl_c [4];
    logic signed [31:0] tbl_x [4];
    logic signed [31:0] tbl_y [4];
    logic signed [63:0] p_x, p_y, v_x, v_y, pv_x, pv_y, pa_x, pa_y;
    logic [12:0]        hold_px, hold_py;
    logic               halted;
    logic [12:0]        reg_w, reg_h;
    logic signed [31:0] reg_q;
    logic [15:0]        reg_dt;
    logic [4:0]         reg_s;

    request_t pending_requests[$];
    pixel_t   expected_pixels[$];
    int       errors = 0;
    int       send_gap = 0;
    int       recv_gap = 0;
    int       hold_left = 0;
    int       idle_cycles = 0;
    bit       quiet = 0;
    bit       in_taken = 0;

    function automatic logic [63:0] mag(input logic signed [63:0] v);
        return v[63] ? -v : v;
    endfunction

    function automatic logic signed [63:0] from_sm(input bit neg, input logic [63:0] m);
        if (neg)
            return m[63] ? SAT_MIN : -m;
        return m[63] ? SAT_MAX : m;
    endfunction

    function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
        logic signed [63:0] s;
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63])
            return a[63] ? SAT_MIN : SAT_MAX;
        return s;
    endfunction

    function automatic logic signed [63:0] ssub(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
        logic signed [63:0] s;
        s = a - b;
        if (a[63] != b[63] && s[63] != a[63])
            return a[63] ? SAT_MIN : SAT_MAX;
        return s;
    endfunction

    function automatic logic [63:0] root_of(input logic [63:0] v);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [63:0] rescale(input logic [63:0] m, input int k);
        if (k >= 0) begin
            if (k >= 64 || m > ({64{1'b1}} >> k)) return {64{1'b1}};
            return m << k;
        end
        return (-k >= 64) ? 64'd0 : m >> (-k);
    endfunction

    function automatic force_t field_at(input logic signed [63:0] px,
                                        input logic signed [63:0] py);
        force_t res;
        logic signed [63:0] ex, ey, dx, dy;
        logic [63:0] mx, my, m, xs, ys, r, f, f2, f3, cm, tx, ty, qm, ax, ay;
        logic [127:0] prod;
        int e;
        ex = 0;
        ey = 0;
        for (int i = 0; i < 4; i++) begin
            dx = ssub(px, 64'(tbl_x[i]) <<< 16);
            dy = ssub(py, 64'(tbl_y[i]) <<< 16);
            mx = mag(dx);
            my = mag(dy);
            m = mx > my ? mx : my;
            if (m == 0) continue;   // source sits on the point
            e = 0;
            while (m >= (64'd1 << 31)) begin m = m >> 1; e++; end
            while (m < (64'd1 << 30)) begin m = m << 1; e--; end
            xs = e >= 0 ? mx >> e : mx << (-e);
            ys = e >= 0 ? my >> e : my << (-e);
            r = root_of(xs * xs + ys * ys);
            f = (64'd1 << 61) / r;
            f2 = (f * f) >> 31;
            f3 = (f2 * f) >> 31;
            cm = mag(64'(tbl_c[i]));
            tx = rescale(cm * ((xs * f3) >> 31), -2 - 2 * e);
            ty = rescale(cm * ((ys * f3) >> 31), -2 - 2 * e);
            ex = sadd(ex, from_sm(tbl_c[i][15] != dx[63], tx));
            ey = sadd(ey, from_sm(tbl_c[i][15] != dy[63], ty));
        end
        qm = mag(64'(reg_q));
        ax = mag(ex);
        ay = mag(ey);
        prod = ax * qm;
        res.fx = from_sm(reg_q[31] != ex[63], prod[127:64] != 0 ? {64{1'b1}} : prod[63:0]);
        prod = ay * qm;
        res.fy = from_sm(reg_q[31] != ey[63], prod[127:64] != 0 ? {64{1'b1}} : prod[63:0]);
        return res;
    endfunction

    function automatic logic signed [63:0] half_dt(input logic signed [63:0] s);
        logic [63:0] m, hi, lo;
        m = mag(s);
        hi = m >> 32;
        lo = m & 64'hFFFF_FFFF;
        return from_sm(s[63], ((hi * reg_dt) << 15) + ((lo * reg_dt) >> 17));
    endfunction

    function automatic logic [12:0] to_pixel(input logic signed [63:0] v, input int lim);
        logic [63:0] p;
        if (v[63]) return 0;
        p = v >> 32;
        return p > lim ? 13'(lim) : 13'(p);
    endfunction

    function automatic int dim_of(input logic [12:0] v);
        return v > MAX_DIM ? MAX_DIM : int'(v);
    endfunction

    function automatic int scale_of();
        return reg_s == 0 ? 1 : int'(reg_s);
    endfunction

    function automatic bit in_frame(input int x, input int y, input int w, input int h);
        return x > 0 && x < w && y > 0 && y < h;
    endfunction

    localparam int MAX_DIM = 4096;

    task automatic reset_model();
        for (int i = 0; i < 4; i++) begin
            tbl_c[i] = RST_SRC_C[i];
            tbl_x[i] = RST_SRC_X[i];
            tbl_y[i] = RST_SRC_Y[i];
        end
        {p_x, p_y, v_x, v_y, pv_x, pv_y, pa_x, pa_y} = '0;
        hold_px = 0;
        hold_py = 0;
        halted = 1;
        reg_w = RST_WIDTH;
        reg_h = RST_HEIGHT;
        reg_q = RST_CHARGE_Q;
        reg_dt = RST_DT;
        reg_s = RST_SCALE;
    endtask

    task automatic predict_request(input request_t rq);
        int w, h, s, x0, y0;
        force_t fa;
        logic signed [63:0] qx, qy;
        pixel_t res;
        w = dim_of(reg_w);
        h = dim_of(reg_h);
        s = scale_of();
        case (rq.op)
            OP_WRITE: begin
                tbl_c[rq.idx] = rq.charge;
                tbl_x[rq.idx] = rq.x;
                tbl_y[rq.idx] = rq.y;
            end
            OP_RESTART: begin
                x0 = w / 10;
                y0 = h / 2;
                p_x = 64'(longint'(x0 - w / 2) * s) <<< 32;
                p_y = 64'(longint'(h / 2 - y0) * s) <<< 32;
                {v_x, v_y, pv_x, pv_y} = '0;
                fa = field_at(p_x, p_y);
                pa_x = fa.fx;
                pa_y = fa.fy;
                hold_px = 13'(x0);
                hold_py = 13'(y0);
                halted = !in_frame(x0, y0, w, h);
            end
            OP_STEP: begin
                if (!halted) begin
                    fa = field_at(p_x, p_y);
                    v_x = sadd(v_x, half_dt(sadd(fa.fx, pa_x)));
                    v_y = sadd(v_y, half_dt(sadd(fa.fy, pa_y)));
                    p_x = sadd(p_x, half_dt(sadd(v_x, pv_x)));
                    p_y = sadd(p_y, half_dt(sadd(v_y, pv_y)));
                    pv_x = v_x;
                    pv_y = v_y;
                    pa_x = fa.fx;
                    pa_y = fa.fy;
                    qx = from_sm(p_x[63], mag(p_x) / 64'(s));
                    qy = from_sm(p_y[63], mag(p_y) / 64'(s));
                    hold_px = to_pixel(sadd(qx, 64'(w / 2) <<< 32), w);
                    hold_py = to_pixel(ssub(64'(h / 2) <<< 32, qy), h);
                    halted = !in_frame(hold_px, hold_py, w, h);
                end
                res.px = hold_px;
                res.py = hold_py;
                res.left = halted;
                expected_pixels.push_back(res);
            end
            default: ;
        endcase
    endtask

    // request driver
    always @(negedge clk) begin
        request_t rq;
        if (rst_n && (!in_valid || in_taken)) begin
            in_taken = 0;
            if (send_gap > 0) begin
                in_valid <= 1'b0;
                send_gap--;
            end else if (!quiet && $urandom_range(0, 15) == 0) begin
                in_valid <= 1'b0;
                send_gap = $urandom_range(0, 16);
            end else if (pending_requests.size() > 0) begin
                rq = pending_requests.pop_front();
                opcode <= rq.op;
                source_index <= rq.idx;
                source_charge <= rq.charge;
                source_x <= rq.x;
                source_y <= rq.y;
                in_valid <= 1'b1;
            end else
                in_valid <= 1'b0;
        end
    end

    // result stall
    always @(negedge clk) begin
        if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left--;
        end else if (recv_gap > 0) begin
            out_stall <= 1'b1;
            recv_gap--;
        end else if (!quiet && $urandom_range(0, 15) == 0) begin
            out_stall <= 1'b1;
            recv_gap = $urandom_range(0, 16);
        end else
            out_stall <= 1'b0;
    end

    // acceptance, checking and watchdog
    always @(posedge clk) begin
        request_t rq;
        pixel_t   exp_px;
        bit       moved;
        moved = 0;
        if (rst_n && in_valid && !in_stall) begin
            rq.op = opcode_t'(opcode);
            rq.idx = source_index;
            rq.charge = source_charge;
            rq.x = source_x;
            rq.y = source_y;
            predict_request(rq);
            in_taken = 1;
            moved = 1;
        end
        if (rst_n && out_valid && !out_stall) begin
            moved = 1;
            if (expected_pixels.size() == 0) begin
                $error("unexpected result pixel_x %0d pixel_y %0d", pixel_x, pixel_y);
                errors++;
            end else begin
                exp_px = expected_pixels.pop_front();
                if (pixel_x !== exp_px.px) begin
                    $error("pixel_x expected %0d actual %0d", exp_px.px, pixel_x);
                    errors++;
                end
                if (pixel_y !== exp_px.py) begin
                    $error("pixel_y expected %0d actual %0d", exp_px.py, pixel_y);
                    errors++;
                end
                if (left_frame !== exp_px.left) begin
                    $error("left_frame expected %0d actual %0d", exp_px.left, left_frame);
                    errors++;
                end
            end
        end
        if (cfg_valid && cfg_ready) moved = 1;
        idle_cycles = moved ? 0 : idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic write_reg(input logic [2:0] index, input logic [31:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        case (index)
            CFG_WIDTH:  reg_w = value[12:0];
            CFG_HEIGHT: reg_h = value[12:0];
            CFG_CHARGE: reg_q = value;
            CFG_STEP:   reg_dt = value[15:0];
            CFG_SCALE:  reg_s = value[4:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic configure(input int w, input int h, input int q, input int dt, input int s);
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
        write_reg(CFG_CHARGE, q);
        write_reg(CFG_STEP, dt);
        write_reg(CFG_SCALE, s);
    endtask

    task automatic push(input opcode_t op, input int idx, input int c, input int x, input int y);
        request_t rq;
        rq.op = op;
        rq.idx = idx;
        rq.charge = c;
        rq.x = x;
        rq.y = y;
        pending_requests.push_back(rq);
    endtask

    // a source position in Q15.16 near the visible world, sometimes anywhere
    function automatic int near_coord(input int dim);
        longint r, v;
        if ($urandom_range(0, 7) == 0) return $urandom;
        r = longint'(dim_of(13'(dim))) * scale_of() / 2 + 1;
        v = (longint'($urandom_range(0, 2 * r)) - r) * 65536 + $urandom_range(0, 65535);
        if (v > 64'sh7FFF_FFFF) v = 64'sh7FFF_FFFF;
        if (v < -64'sh8000_0000) v = -64'sh8000_0000;
        return int'(v);
    endfunction

    // drain the block: no request waiting, no result owed, restart finished
    task automatic drain();
        while (pending_requests.size() > 0 || in_valid || expected_pixels.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic random_phase(input int n);
        int sent, w, h, x0;
        sent = 0;
        while (sent < n) begin
            case ($urandom_range(0, 9))
                0: push(OP_NONE, $urandom, $urandom, $urandom, $urandom);
                1: begin
                    push(OP_STEP, $urandom, $urandom, $urandom, $urandom);
                    sent++;
                end
                default: begin
                    w = dim_of(reg_w);
                    h = dim_of(reg_h);
                    repeat ($urandom_range(0, 2)) begin
                        push(OP_WRITE, $urandom, $urandom, near_coord(w), near_coord(h));
                        sent++;
                    end
                    // occasionally park a source on the start point
                    if ($urandom_range(0, 9) == 0) begin
                        x0 = (w / 10 - w / 2) * scale_of() * 65536;
                        push(OP_WRITE, $urandom, $urandom, x0, 0);
                        sent++;
                    end
                    push(OP_RESTART, $urandom, $urandom, $urandom, $urandom);
                    sent++;
                    repeat ($urandom_range(2, 14)) begin
                        push(OP_STEP, $urandom, $urandom, $urandom, $urandom);
                        sent++;
                    end
                end
            endcase
        end
    endtask

    function automatic int rand_charge();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom_range(0, 1000) - 500;
            default: return int'($urandom_range(0, 40000000)) - 20000000;
        endcase
    endfunction

    initial begin
        reset_model();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: default settings
        push(OP_STEP, 0, 0, 0, 0);
        push(OP_RESTART, 0, 0, 0, 0);
        repeat (3) push(OP_STEP, 0, 0, 0, 0);
        push(OP_NONE, 3, -1, -1, -1);
        push(OP_WRITE, 3, 32767, 32'h7FFF_FFFF, 32'h8000_0000);
        push(OP_WRITE, 2, -32768, 32'h8000_0000, 32'h7FFF_FFFF);
        push(OP_WRITE, 1, 0, 0, 0);
        push(OP_WRITE, 0, 16'h5A5A, (64 - 320) * 2 * 65536, 0);
        push(OP_RESTART, 0, 0, 0, 0);
        repeat (3) push(OP_STEP, 0, 0, 0, 0);
        drain();

        // extremes: smallest and largest frames, strongest charge, longest and zero step, scale limits
        configure(2, 2, 32'h8000_0000, 65535, 16);
        push(OP_RESTART, 0, 0, 0, 0);
        repeat (2) push(OP_STEP, 0, 0, 0, 0);
        drain();
        configure(8191, 8191, 32'h7FFF_FFFF, 65535, 1);
        push(OP_WRITE, 0, 256, 0, 0);
        push(OP_RESTART, 0, 0, 0, 0);
        repeat (3) push(OP_STEP, 0, 0, 0, 0);
        drain();
        configure(1, 4096, 1, 0, 0);
        push(OP_RESTART, 0, 0, 0, 0);
        push(OP_STEP, 0, 0, 0, 0);
        drain();
        configure(4096, 3, -1, 0, 31);
        push(OP_RESTART, 0, 0, 0, 0);
        repeat (2) push(OP_STEP, 0, 0, 0, 0);
        drain();

        for (int ph = 0; ph < 16; ph++) begin
            if (ph % 4 == 3)
                configure(640, 480, rand_charge(), $urandom_range(0, 65535), 2);
            else
                configure($urandom_range(0, 8191), $urandom_range(0, 8191), rand_charge(),
                          $urandom_range(1, 65535), $urandom_range(0, 16));
            quiet = (ph >= 14);
            // receiver holds off while requests keep coming
            if (ph == 5) hold_left = HOLD_CYCLES;
            random_phase(100);
            drain();
        end

        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== charge_trajectory_field_integrator.f =====
design/ctfi_pkg.sv
design/charge_trajectory_field_integrator.sv
sim/charge_trajectory_field_integrator_test.sv
